>>> sv/hbsp_pkg.sv
`default_nettype none

package hbsp_pkg;

    localparam int SLOTS    = 4;
    localparam int TAG_BITS = 32;
    localparam int AGE_BITS = 3;

    // stored widths never exceed the request fields
    localparam int KEEP_TAG = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int KEEP_AGE = (AGE_BITS < 3) ? AGE_BITS : 3;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_NEW      = 3'd1,
        ST_COLLIDED = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } t_status;

    typedef struct packed {
        logic        mode;
        logic [31:0] tag;
        logic [2:0]  age;
        logic [63:0] payload;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot;
        logic [2:0]  found_age;
        logic [63:0] found_payload;
    } t_rsp;

    typedef struct packed {
        logic    load;
        logic    tag_step;
        logic    age_init;
        logic    age_step;
        logic    commit;
        logic    st_we;
        t_status st;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic tag_eq;
        logic age_ne;
    } t_sts;

    // next slot index with wrap
    function automatic t_slot slot_inc(input t_slot k);
        if (k == t_slot'(SLOTS - 1)) begin
            return '0;
        end
        return t_slot'(k + 1'b1);
    endfunction

endpackage

`default_nettype wire

>>> sv/hash_bucket_store_probe_core.sv
`default_nettype none

// One transposition-table bucket of SLOTS entries (tag, age, payload) with a
// rotating last-slot pointer. A request with mode 0 stores, mode 1 probes.
// Each request is loaded, then scanned by tag from the last slot on; a tag
// match ends the scan as a hit or update, a probe without one as a miss. A
// store without a tag match then runs an age scan from the slot after it,
// which ends as new at the first slot of another age, else as collided on
// the slot after the last one. Every request ends with a commit step. The
// entries share one read port, so the scans compare one slot per cycle. The
// result sits in an output register; the next request is taken while it
// waits. The bucket is cleared by reset.
module hash_bucket_store_probe_core
    import hbsp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_rsp o_out_rsp
);

    t_cmd cmd;
    t_sts sts;

    hbsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hbsp_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

>>> sv/hbsp_ctrl.sv
`default_nettype none

module hbsp_ctrl
    import hbsp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  wire  i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAG,
        S_AGE,
        S_COMMIT
    } t_state;

    localparam t_slot CNT_LAST = t_slot'(SLOTS - 1);

    t_state r_state, n_state;
    t_slot  r_cnt, n_cnt;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        o_cmd   = '0;
        o_cmd.st = ST_MISS;
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_TAG;
                end
            end
            S_TAG: begin
                o_cmd.tag_step = 1'b1;
                if (i_sts.tag_eq) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = i_sts.mode ? ST_HIT : ST_UPDATED;
                    n_state     = S_COMMIT;
                end else if (r_cnt == CNT_LAST) begin
                    o_cmd.st_we = 1'b1;
                    if (i_sts.mode) begin
                        o_cmd.st = ST_MISS;
                        n_state  = S_COMMIT;
                    end else begin
                        // no tag match: fall back to the age scan
                        o_cmd.st       = ST_COLLIDED;
                        o_cmd.age_init = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_AGE;
                    end
                end else begin
                    n_cnt = t_slot'(r_cnt + 1'b1);
                end
            end
            S_AGE: begin
                o_cmd.age_step = 1'b1;
                if (i_sts.age_ne) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = ST_NEW;
                    n_state     = S_COMMIT;
                end else if (r_cnt == CNT_LAST) begin
                    n_state = S_COMMIT;
                end else begin
                    n_cnt = t_slot'(r_cnt + 1'b1);
                end
            end
            S_COMMIT: begin
                // wait until the output register is free or being taken
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

`default_nettype wire

>>> sv/hbsp_dpath.sv
`default_nettype none

module hbsp_dpath
    import hbsp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp
);

    logic [KEEP_TAG-1:0] r_tags [SLOTS];
    logic [KEEP_AGE-1:0] r_ages [SLOTS];
    logic [63:0]         r_pays [SLOTS];
    t_slot               r_last;

    logic                r_mode;
    logic [KEEP_TAG-1:0] r_tag;
    logic [KEEP_AGE-1:0] r_age;
    logic [63:0]         r_pay;
    t_slot               r_idx;
    t_slot               r_k;
    t_status             r_st;
    t_rsp                r_rsp;

    t_slot               rd_addr;
    logic [KEEP_TAG-1:0] rd_tag;
    logic [KEEP_AGE-1:0] rd_age;
    logic [63:0]         rd_pay;
    logic [SLOT_W+1:0]   k_ext;
    logic [KEEP_AGE+2:0] age_ext;

    // one read port: scan index while scanning, chosen slot at commit
    assign rd_addr = i_cmd.commit ? r_k : r_idx;
    assign rd_tag  = r_tags[rd_addr];
    assign rd_age  = r_ages[rd_addr];
    assign rd_pay  = r_pays[rd_addr];
    assign k_ext   = {2'b00, r_k};
    assign age_ext = {3'b000, rd_age};

    assign o_sts.mode   = r_mode;
    assign o_sts.tag_eq = (rd_tag == r_tag);
    assign o_sts.age_ne = (rd_age != r_age);
    assign o_rsp        = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_tags[i] <= '0;
                r_ages[i] <= '0;
                r_pays[i] <= '0;
            end
            r_last <= '0;
        end else if (i_cmd.commit) begin
            if (!r_mode) begin
                r_tags[r_k] <= r_tag;
                r_ages[r_k] <= r_age;
                r_pays[r_k] <= r_pay;
                r_last      <= r_k;
            end else if (r_st == ST_HIT) begin
                r_last <= r_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_req.mode;
            r_tag  <= i_req.tag[KEEP_TAG-1:0];
            r_age  <= i_req.age[KEEP_AGE-1:0];
            r_pay  <= i_req.payload;
            r_idx  <= r_last;
        end else if (i_cmd.age_init) begin
            // collided default is the slot after the last one
            r_idx <= slot_inc(r_last);
            r_k   <= slot_inc(r_last);
        end else if (i_cmd.tag_step || i_cmd.age_step) begin
            if ((i_cmd.tag_step && o_sts.tag_eq) || (i_cmd.age_step && o_sts.age_ne)) begin
                r_k <= r_idx;
            end
            r_idx <= slot_inc(r_idx);
        end

        if (i_cmd.st_we) begin
            r_st <= i_cmd.st;
        end

        if (i_cmd.commit) begin
            r_rsp.status <= r_st;
            if (!r_mode) begin
                r_rsp.slot          <= k_ext[1:0];
                r_rsp.found_age     <= '0;
                r_rsp.found_payload <= '0;
            end else if (r_st == ST_HIT) begin
                r_rsp.slot          <= k_ext[1:0];
                r_rsp.found_age     <= age_ext[2:0];
                r_rsp.found_payload <= rd_pay;
            end else begin
                r_rsp.slot          <= '0;
                r_rsp.found_age     <= '0;
                r_rsp.found_payload <= '0;
            end
        end
    end

endmodule

`default_nettype wire
